### hdl/lzd_pkg.sv
// Shared types and constants for the LZ77 token decompressor.
`timescale 1ns / 1ps

package lzd_pkg;

  localparam int BYTE_W            = 8;
  localparam int TOKEN_W           = 16;
  localparam int LANES             = 4;
  localparam int OUT_BYTES_W       = LANES * BYTE_W;
  localparam int OUT_COUNT_W       = 3;
  localparam int OUT_TDATA_W       = 40;
  localparam int OUT_TUSER_W       = 2;
  localparam int QUEUE_DEPTH       = 2;
  localparam int HISTORY_DEPTH_DEF = 65536;

  localparam logic [TOKEN_W-1:0] MATCH_BIAS = 16'd255;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_ERR,
    CMD_MATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  data;
    logic [TOKEN_W-1:0] match_dist;
    logic               last;
  } cmd_t;

endpackage

### hdl/lzd_front.sv
// Token parser: accepts compressed bytes and issues literal, match and error commands.
`timescale 1ns / 1ps

module lzd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lzd_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_last,
  input  logic                      q_full,
  output logic                      q_push,
  output lzd_pkg::cmd_t             q_cmd
);
  import lzd_pkg::*;

  typedef enum logic [1:0] {
    P_LOW,
    P_HIGH,
    P_RUN
  } phase_t;

  phase_t             phase;
  logic [BYTE_W-1:0]  low_byte;
  logic [TOKEN_W-1:0] match_dist;
  logic               accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    q_push    = 1'b0;
    q_cmd     = '0;
    q_cmd.kind = CMD_ERR;
    q_cmd.last = in_last;
    unique case (phase)
      P_LOW: begin
        q_push = accept && in_last;
      end
      P_HIGH: begin
        if (in_byte == '0) begin
          q_push     = accept;
          q_cmd.kind = CMD_LIT;
          q_cmd.data = low_byte;
        end else begin
          q_push = accept && in_last;
        end
      end
      P_RUN: begin
        q_push           = accept;
        q_cmd.kind       = CMD_MATCH;
        q_cmd.data       = in_byte;
        q_cmd.match_dist = match_dist;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_LOW;
    end else if (accept) begin
      unique case (phase)
        P_LOW: begin
          low_byte <= in_byte;
          phase    <= in_last ? P_LOW : P_HIGH;
        end
        P_HIGH: begin
          match_dist <= {in_byte, low_byte} - MATCH_BIAS;
          phase      <= (in_byte == '0 || in_last) ? P_LOW : P_RUN;
        end
        P_RUN: begin
          phase <= P_LOW;
        end
        default: begin
          phase <= P_LOW;
        end
      endcase
    end
  end

endmodule

### hdl/lzd_cmd_fifo.sv
// Short command queue between the token parser and the copy engine.
`timescale 1ns / 1ps

module lzd_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lzd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output lzd_pkg::cmd_t pop_cmd
);
  import lzd_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = slots[rd_idx];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_idx] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_idx <= (wr_idx == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
      end
      if (do_pop) begin
        rd_idx <= (rd_idx == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/lzd_back.sv
// Copy engine: history memory, match copy, result packing and output register.
`timescale 1ns / 1ps

module lzd_back #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  lzd_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  output logic                           m_valid,
  input  logic                           m_ready,
  output logic [lzd_pkg::OUT_TDATA_W-1:0] m_data,
  output logic                           m_last,
  output logic [lzd_pkg::OUT_TUSER_W-1:0] m_user
);
  import lzd_pkg::*;

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int PCW = $clog2(HISTORY_DEPTH + 1);
  localparam int LCW = $clog2(LANES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_WRITE
  } state_t;

  state_t                 state;
  logic [BYTE_W-1:0]      mem [HISTORY_DEPTH];
  logic [BYTE_W-1:0]      rd_data;
  logic [AW-1:0]          wp;
  logic [AW-1:0]          rd_ptr;
  logic [PCW-1:0]         pc;
  logic [TOKEN_W-1:0]     match_dist;
  logic [BYTE_W-1:0]      remaining;
  logic                   last;
  logic [LCW-1:0]         cnt;
  logic [OUT_BYTES_W-1:0] acc;

  logic                   out_free;
  logic                   we;
  logic [BYTE_W-1:0]      wdata;
  logic                   emit;
  logic [OUT_BYTES_W-1:0] emit_bytes;
  logic [OUT_COUNT_W-1:0] emit_count;
  logic                   emit_item_last;
  logic                   emit_end;
  logic                   emit_err;
  logic                   advance;
  logic                   restart;
  logic                   lane_full;
  logic                   too_far;
  logic [OUT_BYTES_W-1:0] acc_next;
  logic [PCW-1:0]         wp_p;
  logic [PCW-1:0]         dist_p;
  logic [PCW-1:0]         src;
  logic [AW-1:0]          wp_inc;
  logic [AW-1:0]          rd_inc;
  logic [PCW-1:0]         pc_inc;

  assign out_free  = !m_valid || m_ready;
  assign lane_full = (cnt == LCW'(LANES - 1)) || (remaining == BYTE_W'(1));
  assign too_far   = 32'(match_dist) > 32'(pc);
  assign acc_next  = acc | (OUT_BYTES_W'(rd_data) << {cnt, 3'b000});
  assign wp_p      = PCW'(wp);
  assign dist_p    = PCW'(match_dist);
  assign src       = (wp_p >= dist_p) ? wp_p - dist_p : wp_p + PCW'(HISTORY_DEPTH) - dist_p;
  assign wp_inc    = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rd_inc    = (rd_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign pc_inc    = (pc == PCW'(HISTORY_DEPTH)) ? pc : pc + 1'b1;

  always_comb begin
    cmd_pop        = 1'b0;
    we             = 1'b0;
    wdata          = rd_data;
    emit           = 1'b0;
    emit_bytes     = '0;
    emit_count     = '0;
    emit_item_last = 1'b1;
    emit_end       = last;
    emit_err       = 1'b0;
    advance        = 1'b0;
    restart        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop  = 1'b1;
          emit_end = cmd.last;
          unique case (cmd.kind)
            CMD_LIT: begin
              we         = 1'b1;
              wdata      = cmd.data;
              emit       = 1'b1;
              emit_bytes = OUT_BYTES_W'(cmd.data);
              emit_count = OUT_COUNT_W'(1);
              restart    = cmd.last;
            end
            CMD_ERR: begin
              emit     = 1'b1;
              emit_err = 1'b1;
              restart  = cmd.last;
            end
            CMD_MATCH: begin
              emit = 1'b0;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_SETUP: begin
        if (too_far) begin
          emit     = out_free;
          emit_err = 1'b1;
          restart  = last && out_free;
        end else if (remaining == '0) begin
          emit    = last && out_free;
          restart = last && out_free;
        end
      end
      S_READ: begin
        emit = 1'b0;
      end
      S_WRITE: begin
        if (!lane_full || out_free) begin
          advance        = 1'b1;
          we             = 1'b1;
          emit           = lane_full;
          emit_bytes     = acc_next;
          emit_count     = OUT_COUNT_W'(cnt) + 1'b1;
          emit_item_last = (remaining == BYTE_W'(1));
          emit_end       = last && (remaining == BYTE_W'(1));
          restart        = last && (remaining == BYTE_W'(1));
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp] <= wdata;
    end
    if (state == S_READ) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
      wp      <= '0;
      pc      <= '0;
    end else begin
      if (emit) begin
        m_valid <= 1'b1;
        m_data  <= {(OUT_TDATA_W - OUT_BYTES_W - OUT_COUNT_W)'(0), emit_count, emit_bytes};
        m_last  <= emit_end;
        m_user  <= {emit_err, emit_item_last};
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (restart) begin
        wp <= '0;
        pc <= '0;
      end else if (we) begin
        wp <= wp_inc;
        pc <= pc_inc;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_pop && cmd.kind == CMD_MATCH) begin
            match_dist <= cmd.match_dist;
            remaining  <= cmd.data;
            last       <= cmd.last;
            state      <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (too_far || remaining == '0) begin
            if (out_free || (!too_far && !last)) begin
              state <= S_IDLE;
            end
          end else begin
            rd_ptr <= AW'(src);
            cnt    <= '0;
            acc    <= '0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (advance) begin
            rd_ptr    <= rd_inc;
            remaining <= remaining - 1'b1;
            if (lane_full) begin
              acc <= '0;
              cnt <= '0;
            end else begin
              acc <= acc_next;
              cnt <= cnt + 1'b1;
            end
            if (remaining == BYTE_W'(1)) begin
              state <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/lz77_token_decompressor.sv
// Top level of the LZ77 token decompressor.
`timescale 1ns / 1ps

// Takes one compressed byte per cycle while the two-entry command queue has room;
// two bytes form a little-endian token (below 256 a literal, otherwise a match of
// distance token - 255 followed by a run-length byte). The copy engine retires a
// literal or an error as it pops the command, and a match through a setup state and
// then a read state and a write state per copied byte, since each byte is read from
// and then written to the single-port history memory; results carry up to four bytes
// and the engine waits while the output register is full before popping a command or
// emitting a result. History contents are not cleared: a produced-byte count limits
// how far back a match may reach, and it returns to zero after each tlast.
module lz77_token_decompressor #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] in_byte
  input  logic                            s_axis_tlast,  // in_last
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lzd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] out_bytes, [34:32] out_count
  output logic                            m_axis_tlast,  // out_stream_end
  output logic [lzd_pkg::OUT_TUSER_W-1:0] m_axis_tuser   // [0] out_item_last, [1] out_error
);
  import lzd_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  lzd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  lzd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  lzd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (m_axis_tdata),
    .m_last    (m_axis_tlast),
    .m_user    (m_axis_tuser)
  );

endmodule

### hdl/lzd_checker.sv
// Port-level assertions for the LZ77 token decompressor, bound to the top level.
`timescale 1ns / 1ps

module lzd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lzd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic [lzd_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  logic [2:0] count;
  assign count = m_axis_tdata[34:32];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> count <= 3'd4)
    else $error("byte count above four");

  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[34:0] == 35'd0 && m_axis_tuser[0])
    else $error("error result carries bytes or is not final");

  a_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("stream end on a non-final result");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && count == 3'd0 && !m_axis_tuser[1] |-> m_axis_tlast
      && m_axis_tdata[31:0] == 32'd0)
    else $error("empty result outside stream end");

endmodule

bind lz77_token_decompressor lzd_checker u_lzd_checker (.*);

### tb/sv/tb.sv
// Testbench for the LZ77 token decompressor: directed and random streams, scoreboard check.
`timescale 1ns / 1ps

typedef enum logic [1:0] {
  PH_LOW,
  PH_HIGH,
  PH_RUN
} token_phase_t;

typedef struct packed {
  logic [31:0] bytes;
  logic [2:0]  count;
  logic        item_last;
  logic        stream_end;
  logic        error;
} out_word_t;

class lz_decode_scoreboard;
  logic [7:0]   history [lzd_pkg::HISTORY_DEPTH_DEF];
  token_phase_t phase;
  logic [7:0]   low_byte;
  int unsigned  distance;
  logic [15:0]  wr_ptr;
  int unsigned  produced;
  out_word_t    words_due[$];
  int           failures;

  function new();
    phase    = PH_LOW;
    low_byte = 8'd0;
    distance = 0;
    wr_ptr   = 16'd0;
    produced = 0;
    failures = 0;
  endfunction

  function logic [7:0] keep_byte(logic [7:0] b);
    history[wr_ptr] = b;
    wr_ptr++;
    if (produced < lzd_pkg::HISTORY_DEPTH_DEF) produced++;
    return b;
  endfunction

  function out_word_t make_word(logic [31:0] bytes, logic [2:0] count, logic error);
    out_word_t w;
    w.bytes      = bytes;
    w.count      = count;
    w.item_last  = 1'b0;
    w.stream_end = 1'b0;
    w.error      = error;
    return w;
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    out_word_t   made[$];
    out_word_t   w;
    logic [15:0] token;
    logic [15:0] src;
    logic [7:0]  copied;
    logic [31:0] acc;
    int          cnt;
    case (phase)
      PH_LOW: begin
        if (last) begin
          made.push_back(make_word(32'd0, 3'd0, 1'b1));
        end else begin
          low_byte = b;
          phase    = PH_HIGH;
        end
      end
      PH_HIGH: begin
        token = {b, low_byte};
        phase = PH_LOW;
        if (b == 8'd0) begin
          made.push_back(make_word({24'd0, keep_byte(low_byte)}, 3'd1, 1'b0));
        end else if (last) begin
          made.push_back(make_word(32'd0, 3'd0, 1'b1));
        end else begin
          distance = {16'd0, token - lzd_pkg::MATCH_BIAS};
          phase    = PH_RUN;
        end
      end
      default: begin
        phase = PH_LOW;
        if (distance > produced) begin
          made.push_back(make_word(32'd0, 3'd0, 1'b1));
        end else begin
          acc = 32'd0;
          cnt = 0;
          repeat (b) begin
            src    = wr_ptr - distance[15:0];
            copied = keep_byte(history[src]);
            acc    = acc | ({24'd0, copied} << (8 * cnt));
            cnt++;
            if (cnt == lzd_pkg::LANES) begin
              made.push_back(make_word(acc, cnt[2:0], 1'b0));
              acc = 32'd0;
              cnt = 0;
            end
          end
          if (cnt > 0) made.push_back(make_word(acc, cnt[2:0], 1'b0));
          if (made.size() == 0 && last) made.push_back(make_word(32'd0, 3'd0, 1'b0));
        end
      end
    endcase
    if (made.size() > 0) begin
      w            = made.pop_back();
      w.item_last  = 1'b1;
      w.stream_end = last;
      made.push_back(w);
    end
    if (last) begin
      phase    = PH_LOW;
      wr_ptr   = 16'd0;
      produced = 0;
    end
    foreach (made[i]) words_due.push_back(made[i]);
  endfunction

  function void check_word(logic [lzd_pkg::OUT_TDATA_W-1:0] data, logic tlast,
                           logic [lzd_pkg::OUT_TUSER_W-1:0] user);
    out_word_t want;
    out_word_t got;
    got.bytes      = data[lzd_pkg::OUT_BYTES_W-1:0];
    got.count      = data[lzd_pkg::OUT_BYTES_W +: lzd_pkg::OUT_COUNT_W];
    got.item_last  = user[0];
    got.error      = user[1];
    got.stream_end = tlast;
    if (words_due.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected transaction: bytes=%h count=%0d item_last=%b end=%b err=%b",
                 got.bytes, got.count, got.item_last, got.stream_end, got.error);
    end else begin
      want = words_due.pop_front();
      if (want !== got) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: exp bytes=%h count=%0d item_last=%b end=%b err=%b, ",
                    "got bytes=%h count=%0d item_last=%b end=%b err=%b"},
                   want.bytes, want.count, want.item_last, want.stream_end, want.error,
                   got.bytes, got.count, got.item_last, got.stream_end, got.error);
      end
    end
  endfunction
endclass

module tb;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 100;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_BYTES = 384;
  localparam int MAX_DIST     = 65280;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = 8'd0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lzd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic [lzd_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

  logic quiet      = 1'b0;
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  logic paused     = 1'b0;
  int   hold_left    = 0;
  int   stall_cycles = 0;
  int   random_bytes = 0;

  lz_decode_scoreboard sb = new();

  lz77_token_decompressor u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 9) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b, last);
  endtask

  task automatic send_literal(input logic [7:0] b, input logic last);
    send_byte(b, 1'b0);
    send_byte(8'd0, last);
  endtask

  task automatic send_match(input int unsigned match_dist, input logic [7:0] run,
                            input logic last);
    logic [15:0] token;
    token = 16'(match_dist + lzd_pkg::MATCH_BIAS);
    send_byte(token[7:0], 1'b0);
    send_byte(token[15:8], 1'b0);
    send_byte(run, last);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.words_due.size() != 0);
  endtask

  task automatic send_random_token();
    int unsigned pick;
    int unsigned room;
    int unsigned match_dist;
    logic [7:0]  run;
    pick = $urandom_range(0, 99);
    room = (sb.produced > MAX_DIST) ? MAX_DIST : sb.produced;
    run  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(17, 255)) : 8'($urandom_range(0, 16));
    if (pick < 45 || (pick < 85 && room == 0)) begin
      send_literal(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
      random_bytes += 2;
    end else if (pick < 85) begin
      if ($urandom_range(0, 2) != 0)
        match_dist = $urandom_range(1, (room < 8) ? room : 8);
      else
        match_dist = $urandom_range(1, room);
      send_match(match_dist, run, $urandom_range(0, 24) == 0);
      random_bytes += 3;
    end else if (pick < 92 && room < MAX_DIST) begin
      send_match($urandom_range(room + 1, MAX_DIST), run, $urandom_range(0, 9) == 0);
      random_bytes += 3;
    end else if (pick < 97) begin
      if ($urandom_range(0, 1) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        random_bytes += 1;
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(1, 255)), 1'b1);
        random_bytes += 2;
      end
    end else begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      random_bytes += 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= (hold_left == 1);
      end else if (hold_req && !hold_taken) begin
        hold_taken    <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_literal(8'h00, 1'b0);
    send_literal(8'hFF, 1'b0);
    send_match(1, 8'd7, 1'b0);
    send_match(3, 8'd0, 1'b0);
    send_match(MAX_DIST, 8'd5, 1'b0);
    send_match(2, 8'd255, 1'b0);
    send_byte(8'h12, 1'b1);
    send_literal(8'h3C, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    send_literal(8'h55, 1'b0);
    send_match(1, 8'd0, 1'b1);
    while (random_bytes < RANDOM_BYTES) begin
      if (random_bytes >= 150 && !hold_req) hold_req <= 1'b1;
      quiet <= (random_bytes >= 300 && random_bytes < 380);
      if (random_bytes >= 240 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
      send_random_token();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.words_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### lz77_token_decompressor.f
hdl/lzd_pkg.sv
hdl/lzd_front.sv
hdl/lzd_cmd_fifo.sv
hdl/lzd_back.sv
hdl/lz77_token_decompressor.sv
hdl/lzd_checker.sv
tb/sv/tb.sv
